### src/cctp_pkg.sv
// Shared constants, types and arctangent table for the cartesian-to-polar CORDIC.
`default_nettype none
package cctp_pkg;

    localparam int DEF_ITERATIONS = 16;
    localparam int DEF_DATA_WIDTH = 16;

    localparam int IN_W  = 15;
    localparam int MAG_W = 15;
    localparam int ANG_W = 16;
    // angle accumulator: base angle plus full table sum stays well inside 18 bits
    localparam int ACC_W = 18;

    localparam int HALF_PI_Q13 = 12868;
    localparam int PI_Q13      = 25736;
    localparam int GAIN_Q16    = 39797;
    localparam int MAG_MAX     = 32767;

    typedef logic signed [ACC_W-1:0] ang_acc_t;

    // atan(2^-idx) in Q3.13, rounded to nearest
    function automatic ang_acc_t atan_q13(input int unsigned idx);
        ang_acc_t val;
        case (idx)
            0:       val = ACC_W'(6434);
            1:       val = ACC_W'(3798);
            2:       val = ACC_W'(2007);
            3:       val = ACC_W'(1019);
            4:       val = ACC_W'(511);
            5:       val = ACC_W'(256);
            6:       val = ACC_W'(128);
            7:       val = ACC_W'(64);
            8:       val = ACC_W'(32);
            9:       val = ACC_W'(16);
            10:      val = ACC_W'(8);
            11:      val = ACC_W'(4);
            12:      val = ACC_W'(2);
            13:      val = ACC_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

### src/cctp_stage.sv
// One registered CORDIC vectoring micro-rotation.
`default_nettype none
module cctp_stage
    import cctp_pkg::*;
#(
    parameter int W     = 22,
    parameter int SHIFT = 0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] x_in,
    input  wire logic signed [W-1:0] y_in,
    input  wire ang_acc_t            ang_in,
    output logic                     out_valid,
    output logic signed [W-1:0]      x_out,
    output logic signed [W-1:0]      y_out,
    output ang_acc_t                 ang_out
);

    localparam ang_acc_t ATAN = atan_q13(SHIFT);

    logic                valid_reg;
    logic signed [W-1:0] x_reg, y_reg, x_next, y_next;
    ang_acc_t            ang_reg, ang_next;
    logic signed [W-1:0] x_sh, y_sh;

    // arithmetic shift floors, as the rotation needs
    assign x_sh = x_in >>> SHIFT;
    assign y_sh = y_in >>> SHIFT;

    always_comb begin
        if (!y_in[W-1]) begin
            x_next   = x_in + y_sh;
            y_next   = y_in - x_sh;
            ang_next = ang_in + ATAN;
        end else begin
            x_next   = x_in - y_sh;
            y_next   = y_in + x_sh;
            ang_next = ang_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign ang_out   = ang_reg;

endmodule
`default_nettype wire

### src/cctp_scale.sv
// Gain compensation, rounding and saturation: two register stages ending in the output register.
`default_nettype none
module cctp_scale
    import cctp_pkg::*;
#(
    parameter int W     = 22,
    parameter int GUARD = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [W-1:0] x_in,
    input  wire ang_acc_t            ang_in,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [MAG_W-1:0]         m_magnitude,
    output logic signed [ANG_W-1:0]  m_angle
);

    // x is split into two narrow partial products
    localparam int LW = (GUARD > 0) ? GUARD : 1;
    localparam int HW = W - 1 - LW;
    localparam int PW = W + 16;

    localparam ang_acc_t PI_A   = ACC_W'(PI_Q13);
    localparam ang_acc_t M_PI_A = -ACC_W'(PI_Q13);
    localparam logic [15:0] GAIN = 16'(GAIN_Q16);

    logic load1, load2;
    logic v1_reg, v2_reg;

    logic [W-1:0]       x_c;
    logic [HW+15:0]     ph_reg, ph_next;
    logic [LW+15:0]     pl_reg, pl_next;
    logic signed [ANG_W-1:0] ang1_reg, ang1_next;

    logic [PW-1:0]      sum;
    logic [PW-17-GUARD:0] mag_full;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic signed [ANG_W-1:0] ang2_reg;

    assign load2    = !v2_reg || m_ready;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    always_comb begin
        x_c     = x_in[W-1] ? '0 : x_in;
        ph_next = (HW+16)'(x_c[W-2:LW]) * (HW+16)'(GAIN);
        pl_next = (LW+16)'(x_c[LW-1:0]) * (LW+16)'(GAIN);
        if (ang_in > PI_A) begin
            ang1_next = ANG_W'(PI_A);
        end else if (ang_in < M_PI_A) begin
            ang1_next = ANG_W'(M_PI_A);
        end else begin
            ang1_next = ANG_W'(ang_in);
        end
    end

    always_comb begin
        sum      = (PW'(ph_reg) << LW) + PW'(pl_reg) + (PW'(1) << (15 + GUARD));
        mag_full = sum[PW-1:16+GUARD];
        if (|mag_full[PW-17-GUARD:MAG_W]) begin
            mag_next = MAG_W'(MAG_MAX);
        end else begin
            mag_next = mag_full[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (load1) begin
                v1_reg <= in_valid;
            end
            if (load2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load1 && in_valid) begin
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            ang1_reg <= ang1_next;
        end
        if (load2 && v1_reg) begin
            mag_reg  <= mag_next;
            ang2_reg <= ang1_reg;
        end
    end

    assign m_valid     = v2_reg;
    assign m_magnitude = mag_reg;
    assign m_angle     = ang2_reg;

endmodule
`default_nettype wire

### src/cordic_cart_to_polar.sv
// Cartesian-to-polar converter: CORDIC vectoring pipeline, one point per cycle unless m_ready stalls.
//
// Input channel s_valid/s_ready carries s_x_coord and s_y_coord (signed Q1.14).
// Result channel m_valid/m_ready carries m_magnitude (unsigned Q1.14, saturated)
// and m_angle (signed Q3.13 radians, clamped to +/-pi).
// Exactly one result per input transfer, in order.
//
// From input transfer to m_valid a point passes one stage for the +/-90 degree
// pre-rotation, one per micro-rotation, one for the gain partial products and
// one for rounding/saturation into the output register. Throughput is one point
// per clock unless m_ready stalls the output; each stage holds one point.
//
// Each stage carries its own valid bit and loads when it is empty or when the
// stage after it loads, so a stall on m_ready fills empty stages first and
// s_ready drops only once the whole pipeline is full. Nothing is lost or repeated.
// Synchronous reset (aresetn low) empties every stage; data registers are not
// cleared.
`default_nettype none
module cordic_cart_to_polar
    import cctp_pkg::*;
#(
    parameter int ITERATIONS = DEF_ITERATIONS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [IN_W-1:0]  s_x_coord,
    input  wire logic signed [IN_W-1:0]  s_y_coord,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [MAG_W-1:0]             m_magnitude,
    output logic signed [ANG_W-1:0]      m_angle
);

    localparam int GUARD = DATA_WIDTH - 12;
    localparam int W     = 18 + GUARD;

    localparam ang_acc_t HALF_PI_A = ACC_W'(HALF_PI_Q13);

    logic                vld  [0:ITERATIONS];
    logic                ld   [0:ITERATIONS];
    logic signed [W-1:0] xs   [0:ITERATIONS];
    logic signed [W-1:0] ys   [0:ITERATIONS];
    ang_acc_t            angs [0:ITERATIONS];

    logic                sc_ready;

    // pre-rotation stage
    logic                v0_reg;
    logic signed [W-1:0] x0_reg, y0_reg, x0_next, y0_next;
    ang_acc_t            a0_reg, a0_next;
    logic signed [W-1:0] xi_w, yi_w;

    assign xi_w = W'(s_x_coord);
    assign yi_w = W'(s_y_coord);

    always_comb begin
        if (!s_y_coord[IN_W-1]) begin
            x0_next = yi_w <<< GUARD;
            y0_next = (-xi_w) <<< GUARD;
            a0_next = HALF_PI_A;
        end else begin
            x0_next = (-yi_w) <<< GUARD;
            y0_next = xi_w <<< GUARD;
            a0_next = -HALF_PI_A;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ld[0]) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0] && s_valid) begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            a0_reg <= a0_next;
        end
    end

    assign vld[0]  = v0_reg;
    assign xs[0]   = x0_reg;
    assign ys[0]   = y0_reg;
    assign angs[0] = a0_reg;
    assign s_ready = ld[0];

    genvar k;
    generate
        for (k = 0; k <= ITERATIONS; k++) begin : g_load
            if (k == ITERATIONS) begin : g_last
                assign ld[k] = !vld[k] || sc_ready;
            end else begin : g_mid
                assign ld[k] = !vld[k] || ld[k+1];
            end
        end

        for (k = 0; k < ITERATIONS; k++) begin : g_rot
            cctp_stage #(
                .W     (W),
                .SHIFT (k)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load      (ld[k+1]),
                .in_valid  (vld[k]),
                .x_in      (xs[k]),
                .y_in      (ys[k]),
                .ang_in    (angs[k]),
                .out_valid (vld[k+1]),
                .x_out     (xs[k+1]),
                .y_out     (ys[k+1]),
                .ang_out   (angs[k+1])
            );
        end
    endgenerate

    cctp_scale #(
        .W     (W),
        .GUARD (GUARD)
    ) u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (vld[ITERATIONS]),
        .in_ready    (sc_ready),
        .x_in        (xs[ITERATIONS]),
        .ang_in      (angs[ITERATIONS]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_magnitude (m_magnitude),
        .m_angle     (m_angle)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the cartesian-to-polar CORDIC pipeline.
`timescale 1ns / 1ps
module tb_top
    import cctp_pkg::*;
();

    // Expected-result store with its own bit-true model of the vectoring pipeline.
    class polar_scoreboard;
        typedef struct {
            logic signed [IN_W-1:0]  x;
            logic signed [IN_W-1:0]  y;
            logic [MAG_W-1:0]        mag;
            logic signed [ANG_W-1:0] ang;
        } polar_exp_t;

        polar_exp_t polar_q[$];
        int         errors;
        int         atan_tab[16] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                     32, 16, 8, 4, 2, 1, 0, 0};

        function void compute_polar(input logic signed [IN_W-1:0] xi,
                                    input logic signed [IN_W-1:0] yi,
                                    output logic [MAG_W-1:0] mag,
                                    output logic signed [ANG_W-1:0] ang);
            longint xr, yr, acc, xs, ys, prod;
            if (yi >= 0) begin
                xr  = yi;
                yr  = -longint'(xi);
                acc = 12868;
            end else begin
                xr  = -longint'(yi);
                yr  = xi;
                acc = -12868;
            end
            // four guard bits below the Q1.14 point
            xr = xr * 16;
            yr = yr * 16;
            for (int j = 0; j < 16; j++) begin
                xs = xr >>> j;
                ys = yr >>> j;
                if (yr >= 0) begin
                    xr  = xr + ys;
                    yr  = yr - xs;
                    acc = acc + atan_tab[j];
                end else begin
                    xr  = xr - ys;
                    yr  = yr + xs;
                    acc = acc - atan_tab[j];
                end
            end
            if (acc > 25736)
                acc = 25736;
            if (acc < -25736)
                acc = -25736;
            if (xr < 0)
                xr = 0;
            prod = (xr * 39797 + (longint'(1) << 19)) >>> 20;
            if (prod > 32767)
                prod = 32767;
            mag = prod[MAG_W-1:0];
            ang = acc[ANG_W-1:0];
        endfunction

        task report(input string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task note_input(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y);
            polar_exp_t e;
            e.x = x;
            e.y = y;
            compute_polar(x, y, e.mag, e.ang);
            polar_q.push_back(e);
        endtask

        task check_result(input logic [MAG_W-1:0] mag, input logic signed [ANG_W-1:0] ang);
            polar_exp_t e;
            if (polar_q.size() == 0) begin
                report($sformatf("unexpected result mag=%0d ang=%0d", mag, ang));
            end else begin
                e = polar_q.pop_front();
                if (mag !== e.mag)
                    report($sformatf("(%0d,%0d) magnitude %0d, want %0d",
                                     e.x, e.y, mag, e.mag));
                if (ang !== e.ang)
                    report($sformatf("(%0d,%0d) angle %0d, want %0d",
                                     e.x, e.y, ang, e.ang));
            end
        endtask

        function int pending();
            return polar_q.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_x_coord = '0;
    logic signed [IN_W-1:0]  s_y_coord = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [MAG_W-1:0]        m_magnitude;
    logic signed [ANG_W-1:0] m_angle;

    bit              in_fire;
    bit              out_fire;
    polar_scoreboard sb;
    int unsigned     rx_cycle;
    int unsigned     rx_mode;

    cordic_cart_to_polar u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_coord   (s_x_coord),
        .s_y_coord   (s_y_coord),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_magnitude (m_magnitude),
        .m_angle     (m_angle)
    );

    always #6 aclk = ~aclk;

    // Handshakes are sampled mid-cycle, where everything has settled; the flags
    // tell the driver at the next rising edge whether a transfer took place.
    always @(negedge aclk) begin
        in_fire  = aresetn && (s_valid === 1'b1) && (s_ready === 1'b1);
        out_fire = aresetn && (m_valid === 1'b1) && (m_ready === 1'b1);
        if (in_fire)
            sb.note_input(s_x_coord, s_y_coord);
        if (out_fire)
            sb.check_result(m_magnitude, m_angle);
    end

    // Receiver back-pressure: switch style each time the low byte of rx_cycle is zero
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[7:0] == 8'd0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= ((rx_cycle % 7) < 3);
        endcase
    end

    task send_point(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y);
        s_valid   <= 1'b1;
        s_x_coord <= x;
        s_y_coord <= y;
        do
            @(posedge aclk);
        while (!in_fire);
    endtask

    task drain_pipeline();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic signed [IN_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return IN_W'(-16384);
            1: return IN_W'(-1);
            2: return IN_W'(0);
            3: return IN_W'(1);
            default: return IN_W'(16383);
        endcase
    endfunction

    task gen_point(output logic signed [IN_W-1:0] x, output logic signed [IN_W-1:0] y);
        int unsigned kind;
        logic [IN_W-1:0] r;
        kind = $urandom_range(0, 9);
        r    = IN_W'($urandom());
        case (kind)
            6: begin
                x = IN_W'($signed($urandom_range(0, 16)) - 8);
                y = IN_W'($signed($urandom_range(0, 16)) - 8);
            end
            7: begin
                // on an axis
                if ($urandom_range(0, 1)) begin
                    x = IN_W'($urandom());
                    y = '0;
                end else begin
                    x = '0;
                    y = IN_W'($urandom());
                end
            end
            8: begin
                // on a diagonal
                x = IN_W'($urandom_range(0, 16383));
                y = $urandom_range(0, 1) ? x : -x;
                if ($urandom_range(0, 1))
                    x = -x;
            end
            9: begin
                x = pick_extreme();
                y = pick_extreme();
            end
            default: begin
                x = IN_W'($urandom());
                y = r;
            end
        endcase
    endtask

    initial begin
        logic signed [IN_W-1:0] px, py;
        int burst_len, gap, sent;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners, back to back
        send_point(0, 0);
        send_point(16383, 16383);
        send_point(-16384, -16384);
        send_point(16383, -16384);
        send_point(-16384, 16383);
        send_point(16383, 0);
        send_point(-16384, 0);
        send_point(0, 16383);
        send_point(0, -16384);
        send_point(-1, 0);
        send_point(-16384, -1);
        send_point(-1, -1);
        send_point(1, 1);
        send_point(0, -1);
        send_point(1, 0);
        send_point(-16384, 1);
        send_point(12000, 12000);
        send_point(-12000, 12000);
        send_point(5, -16384);
        send_point(-21, 16383);
        drain_pipeline();

        sent = 0;
        while (sent < 1750) begin
            burst_len = $urandom_range(1, 40);
            for (int i = 0; i < burst_len; i++) begin
                gen_point(px, py);
                send_point(px, py);
                sent++;
            end
            if (sent >= 875 && sent < 875 + burst_len)
                drain_pipeline();
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end

        drain_pipeline();
        repeat (40) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("[cordic_cart_to_polar] OK");
        else
            $display("[cordic_cart_to_polar] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[cordic_cart_to_polar] ERROR");
        $finish;
    end

endmodule
